// ----- src/b64d_pkg.sv -----
// Shared types and constants for the base64url stream decoder.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='

  // One queue entry: the results caused by one input item.
  // data holds up to three bytes, the first to leave in [23:16].
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  cnt;         // number of results, 1..3
    logic        byte_valid;
    logic        bad;
    logic        last;
  } b64d_entry_t;

  typedef struct packed {
    logic        valid;
    b64d_entry_t entry;
  } b64d_head_t;

  // {invalid, value}: value is 0 for characters outside the alphabet.
  function automatic logic [6:0] sym_value(input logic [7:0] s);
    logic [6:0] r;
    begin
      r = 7'h40;
      if (s inside {[8'h41:8'h5a]}) begin
        r = {1'b0, 6'(s - 8'h41)};
      end else if (s inside {[8'h61:8'h7a]}) begin
        r = {1'b0, 6'(s - 8'h61 + 8'd26)};
      end else if (s inside {[8'h30:8'h39]}) begin
        r = {1'b0, 6'(s - 8'h30 + 8'd52)};
      end else if (s == 8'h2d) begin
        r = {1'b0, 6'd62};
      end else if (s == 8'h5f) begin
        r = {1'b0, 6'd63};
      end
      return r;
    end
  endfunction

endpackage

// ----- src/b64d_front.sv -----
// Front end: accepts characters, tracks group and message state, and
// pushes one entry per item that causes results. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            symbol,
  input  logic                  final_symbol,
  input  logic                  full,
  output logic                  push,
  output b64d_pkg::b64d_entry_t entry
);
  import b64d_pkg::*;

  logic [1:0]  group_fill, group_fill_next;
  logic [17:0] sextet_accumulator, sextet_accumulator_next;
  logic        group_has_invalid, group_has_invalid_next;
  logic        padding_seen, padding_seen_next;
  logic        error_latched, error_latched_next;

  logic        accept;
  logic [6:0]  sv;
  logic [5:0]  v;
  logic        inv;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign sv       = sym_value(symbol);
  assign inv      = sv[6];
  assign v        = sv[5:0];

  always_comb begin
    logic [1:0]  f;
    logic [17:0] a;
    logic        gi, ps, el, have;
    f    = group_fill;
    a    = sextet_accumulator;
    gi   = group_has_invalid;
    ps   = padding_seen;
    el   = error_latched;
    have = 1'b0;
    entry = '0;

    if (!el && !ps) begin
      if (symbol == CHAR_PAD) begin
        ps = 1'b1;
      end else if (f == 2'd3) begin
        have = 1'b1;
        if (gi || inv) begin
          el = 1'b1;
          entry.cnt = 2'd1;
          entry.bad = 1'b1;
        end else begin
          entry.data       = {a, v};
          entry.cnt        = 2'd3;
          entry.byte_valid = 1'b1;
        end
        f  = 2'd0;
        a  = '0;
        gi = 1'b0;
      end else begin
        a  = {a[11:0], v};
        f  = f + 2'd1;
        gi = gi | inv;
      end
    end

    if (final_symbol) begin
      if (!el && f >= 2'd2) begin
        have = 1'b1;
        if (gi) begin
          el = 1'b1;
          entry.cnt = 2'd1;
          entry.bad = 1'b1;
        end else if (f == 2'd2) begin
          entry.data       = {a[11:4], 16'h0000};
          entry.cnt        = 2'd1;
          entry.byte_valid = 1'b1;
        end else begin
          entry.data       = {a[17:10], a[9:2], 8'h00};
          entry.cnt        = 2'd2;
          entry.byte_valid = 1'b1;
        end
      end
      if (!have) begin
        entry.cnt = 2'd1;
        entry.bad = el;
      end
      have       = 1'b1;
      entry.last = 1'b1;
      f  = 2'd0;
      a  = '0;
      gi = 1'b0;
      ps = 1'b0;
      el = 1'b0;
    end

    push                    = accept && have;
    group_fill_next         = f;
    sextet_accumulator_next = a;
    group_has_invalid_next  = gi;
    padding_seen_next       = ps;
    error_latched_next      = el;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill         <= '0;
      sextet_accumulator <= '0;
      group_has_invalid  <= 1'b0;
      padding_seen       <= 1'b0;
      error_latched      <= 1'b0;
    end else if (accept) begin
      group_fill         <= group_fill_next;
      sextet_accumulator <= sextet_accumulator_next;
      group_has_invalid  <= group_has_invalid_next;
      padding_seen       <= padding_seen_next;
      error_latched      <= error_latched_next;
    end
  end

`ifndef ASSERT_OFF
  a_empty_group_clear: assert property (@(posedge clk) disable iff (rst)
    group_fill == 2'd0 |-> sextet_accumulator == '0 && !group_has_invalid)
    else $error("empty group holds data");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    accept && final_symbol |=> group_fill == 2'd0 && !padding_seen && !error_latched)
    else $error("message state kept past final item");
  a_final_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && final_symbol |-> push && entry.last)
    else $error("final item gave no end result");
`endif

endmodule

// ----- src/b64d_queue.sv -----
// Short entry queue between front and back end.
// Depends on b64d_pkg for the entry type.
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output b64d_pkg::b64d_head_t  head
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_entry_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == FULL_CNT;
  assign head.valid = count != '0;
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

// ----- src/b64d_back.sv -----
// Back end: unpacks queue entries into single results and holds them
// in the output register. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  b64d_pkg::b64d_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           data_byte,
  output logic                 byte_valid,
  output logic                 message_end,
  output logic                 bad_symbol
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  assign load    = head.valid && (!out_valid || out_ready);
  assign at_last = idx == head.entry.cnt - 2'd1;
  assign pop     = load && at_last;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.entry.data[23:16];
      2'd1:    sel_byte = head.entry.data[15:8];
      default: sel_byte = head.entry.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte   <= sel_byte;
      byte_valid  <= head.entry.byte_valid;
      bad_symbol  <= head.entry.bad;
      message_end <= head.entry.last && at_last;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> idx < head.entry.cnt)
    else $error("result index beyond entry");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head.valid |-> idx == 2'd0)
    else $error("index left set with empty queue");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({data_byte, byte_valid, message_end, bad_symbol}))
    else $error("output item changed while stalled");
`endif

endmodule

// ----- src/base64url_stream_decoder.sv -----
// Base64url stream decoder, top level.
// Channels: slave side takes one character per item (tdata = symbol, tlast marks
// the last character of a message). Master side gives one result per item:
// tdata = decoded byte, tuser[0] = byte valid, tuser[1] = bad symbol,
// tlast = message end. Every message ends with exactly one result with tlast.
// Four characters give three bytes; a 2- or 3-character tail gives one or two
// bytes; the first '=' ends decoding for the message. An invalid character (but
// not in a 1-character tail) gives one result with tuser = 2'b10; input is then
// dropped until message end, and the consumer discards that message's bytes
// when the end result has tuser[1]. Throughput: one character per cycle while
// the queue is not full; the back end drains one result per cycle while the
// receiver is ready, and a group of four characters yields three results.
// The first result of an item is written into the entry queue and then loaded
// into the output register that drives m_axis_tvalid.
// The entry queue (QUEUE_DEPTH entries) absorbs bursts of up to three results
// per item; s_axis_tready drops only while it is full.
// When the receiver stalls, the output register holds its item and the queue
// fills, then input stalls. Reset clears all message state and empties the queue.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
`timescale 1ns / 1ps

module base64url_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] bad_symbol
  output logic       m_axis_tlast
);
  import b64d_pkg::*;

  logic        full;
  logic        push;
  logic        pop;
  b64d_entry_t entry;
  b64d_head_t  head;

  b64d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .symbol       (s_axis_tdata),
    .final_symbol (s_axis_tlast),
    .full         (full),
    .push         (push),
    .entry        (entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (full),
    .head       (head)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .data_byte   (m_axis_tdata),
    .byte_valid  (m_axis_tuser[0]),
    .message_end (m_axis_tlast),
    .bad_symbol  (m_axis_tuser[1])
  );

endmodule
